FILE: rtl/core/quoted_string_unescaper_core_defines.svh
// Assertion macros shared by the unescaper checker
`ifndef QUOTED_STRING_UNESCAPER_CORE_DEFINES_SVH
`define QUOTED_STRING_UNESCAPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define QSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define QSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/qsu_pkg.sv
// Types and constants for the quoted string unescaper
package qsu_pkg;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BODY = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX1 = 3'd3,
		PH_HEX2 = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_NOQUOTE = 3'd1,
		ERR_EOF     = 3'd2,
		ERR_NEWLINE = 3'd3,
		ERR_ESCAPE  = 3'd4,
		ERR_HEX     = 3'd5
	} err_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;

	localparam int ODATA_W = 16;

	typedef struct packed {
		logic       has_result;
		kind_t      kind;
		logic [7:0] byte_out;
		err_t       error_code;
		logic       last;
		phase_t     next_phase;
		logic [3:0] next_nibble;
	} dec_t;

endpackage

FILE: rtl/core/qsu_decode.sv
// Per-character decode: next phase, hex nibble and optional result
module qsu_decode
	import qsu_pkg::*;
(
	input  phase_t     phase,
	input  logic [3:0] high_nibble,
	input  logic [7:0] ch,
	input  logic       at_end,
	output dec_t       dec
);

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		logic       ok;
		d  = 8'd0;
		ok = 1'b0;
		if (c >= CH_0 && c <= CH_9) begin
			d  = c - CH_0;
			ok = 1'b1;
		end else if (c >= CH_LA && c <= CH_LF_HEX) begin
			d  = c - CH_LA + 8'd10;
			ok = 1'b1;
		end else if (c >= CH_UA && c <= CH_UF) begin
			d  = c - CH_UA + 8'd10;
			ok = 1'b1;
		end
		return {ok, d[3:0]};
	endfunction

	logic [4:0] hex;

	assign hex = hex_digit(ch);

	always_comb begin
		dec.has_result  = 1'b0;
		dec.kind        = KIND_DATA;
		dec.byte_out    = 8'd0;
		dec.error_code  = ERR_NONE;
		dec.last        = 1'b0;
		dec.next_phase  = phase;
		dec.next_nibble = high_nibble;
		case (phase)
			PH_BODY: begin
				if (at_end) begin
					dec.has_result = 1'b1;
					dec.error_code = ERR_EOF;
				end else if (ch == CH_LF) begin
					dec.has_result = 1'b1;
					dec.error_code = ERR_NEWLINE;
				end else if (ch == CH_QUOTE) begin
					dec.has_result = 1'b1;
					dec.kind       = KIND_DONE;
					dec.last       = 1'b1;
					dec.next_phase = PH_IDLE;
				end else if (ch == CH_BSLASH) begin
					dec.next_phase = PH_ESC;
				end else begin
					dec.has_result = 1'b1;
					dec.byte_out   = ch;
				end
			end
			PH_ESC: begin
				dec.next_phase = PH_BODY;
				if (at_end) begin
					dec.has_result = 1'b1;
					dec.error_code = ERR_ESCAPE;
				end else begin
					case (ch)
						CH_T: begin
							dec.has_result = 1'b1;
							dec.byte_out   = CH_TAB;
						end
						CH_N: begin
							dec.has_result = 1'b1;
							dec.byte_out   = CH_LF;
						end
						CH_R: begin
							dec.has_result = 1'b1;
							dec.byte_out   = CH_CR;
						end
						CH_QUOTE, CH_SQUOTE, CH_BSLASH: begin
							dec.has_result = 1'b1;
							dec.byte_out   = ch;
						end
						CH_X: begin
							dec.next_phase  = PH_HEX1;
							dec.next_nibble = 4'd0;
						end
						default: begin
							dec.has_result = 1'b1;
							dec.error_code = ERR_ESCAPE;
						end
					endcase
				end
			end
			PH_HEX1: begin
				if (at_end || !hex[4]) begin
					dec.has_result = 1'b1;
					dec.error_code = ERR_HEX;
				end else begin
					dec.next_nibble = hex[3:0];
					dec.next_phase  = PH_HEX2;
				end
			end
			PH_HEX2: begin
				if (at_end || !hex[4]) begin
					dec.has_result = 1'b1;
					dec.error_code = ERR_HEX;
				end else begin
					dec.has_result  = 1'b1;
					dec.byte_out    = {high_nibble, hex[3:0]};
					dec.next_nibble = 4'd0;
					dec.next_phase  = PH_BODY;
				end
			end
			default: begin
				if (at_end || ch != CH_QUOTE) begin
					dec.has_result = 1'b1;
					dec.error_code = ERR_NOQUOTE;
				end else begin
					dec.next_phase  = PH_BODY;
					dec.next_nibble = 4'd0;
				end
			end
		endcase
		// any error ends the string and returns to idle
		if (dec.error_code != ERR_NONE) begin
			dec.kind        = KIND_ERR;
			dec.last        = 1'b1;
			dec.next_phase  = PH_IDLE;
			dec.next_nibble = 4'd0;
		end
	end

endmodule

FILE: rtl/core/quoted_string_unescaper_core.sv
// Top level of the quoted string unescaper: input stage, decode and result register
//
// Input channel s_axis: one character beat per handshake, tdata carries the
// character and tuser flags end of input in place of a character.
// Output channel m_axis: at most one result beat per input beat; tuser gives
// the kind (data byte, string complete, error), tdata the decoded byte and
// the error code, tlast marks the beat that ends the string.
// Throughput is one character per cycle while the receiver does not stall,
// set by the single decode step between the input register and the result register.
// Each character is decoded from the input register and its result is then
// held in the result register for m_axis; a backslash, the x and first digit
// of a \x escape and an opening quote give no result.
// Reset clears both stages and returns the decoder to awaiting an opening
// quote. When the receiver stalls, the result register holds its beat and
// the input register holds the next character; s_axis_tready drops only
// when both are full and the pending character would produce a result.
module quoted_string_unescaper_core
	import qsu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] ch
	input  logic [0:0]           s_axis_tuser,  // [0] at_end
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [ODATA_W-1:0]   m_axis_tdata,  // [7:0] byte_out, [10:8] error_code
	output logic [1:0]           m_axis_tuser,  // [1:0] kind
	output logic                 m_axis_tlast   // last
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       at_end_s1;

	phase_t     phase_q;
	logic [3:0] nibble_q;

	logic       m_valid_q;
	kind_t      m_kind_q;
	logic [7:0] m_byte_q;
	err_t       m_err_q;
	logic       m_last_q;

	dec_t       dec;
	logic       out_free;
	logic       s1_adv;

	qsu_decode u_decode (
		.phase       (phase_q),
		.high_nibble (nibble_q),
		.ch          (ch_s1),
		.at_end      (at_end_s1),
		.dec         (dec)
	);

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s1_adv        = valid_s1 && (!dec.has_result || out_free);
	assign s_axis_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1     <= s_axis_tdata;
			at_end_s1 <= s_axis_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			nibble_q <= 4'd0;
		end else if (s1_adv) begin
			phase_q  <= dec.next_phase;
			nibble_q <= dec.next_nibble;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_adv && dec.has_result) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && dec.has_result) begin
			m_kind_q <= dec.kind;
			m_byte_q <= dec.byte_out;
			m_err_q  <= dec.error_code;
			m_last_q <= dec.last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(ODATA_W - 11){1'b0}}, m_err_q, m_byte_q};
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;

endmodule

FILE: rtl/core/qsu_checker.sv
// Port-level checks on the quoted string unescaper, bound to the top level
`include "quoted_string_unescaper_core_defines.svh"

module qsu_checker
	import qsu_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [ODATA_W-1:0] m_axis_tdata,
	input logic [1:0]         m_axis_tuser,
	input logic               m_axis_tlast
);

	`QSU_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
		"stalled output beat changed")
	`QSU_ASSERT_NOW(a_kind_legal, clk, arst_n, m_axis_tvalid,
		m_axis_tuser == KIND_DATA || m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_ERR,
		"output kind out of range")
	`QSU_ASSERT_NOW(a_data_beat, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_DATA,
		!m_axis_tlast && m_axis_tdata[10:8] == ERR_NONE, "data beat flagged last or with error")
	`QSU_ASSERT_NOW(a_end_beat, clk, arst_n, m_axis_tvalid && m_axis_tuser != KIND_DATA,
		m_axis_tlast && m_axis_tdata[7:0] == 8'd0, "ending beat not last or carries a byte")
	`QSU_ASSERT_NOW(a_err_code, clk, arst_n, m_axis_tvalid,
		(m_axis_tuser == KIND_ERR) == (m_axis_tdata[10:8] != ERR_NONE),
		"error code does not match kind")

endmodule

bind quoted_string_unescaper_core qsu_checker u_qsu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: test/tb_quoted_string_unescaper_core.sv
// Self-checking testbench for the quoted string unescaper core: directed and random character streams
module tb_quoted_string_unescaper_core;
	import qsu_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
	} char_beat_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_val;
		err_t       err;
		logic       last;
	} decode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = 8'h00;  // [7:0] ch
	logic [0:0]         s_axis_tuser = 1'b0;   // [0] at_end
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [ODATA_W-1:0] m_axis_tdata;          // [7:0] byte_out, [10:8] error_code
	logic [1:0]         m_axis_tuser;          // [1:0] kind
	logic               m_axis_tlast;

	char_beat_t pending_chars[$];
	decode_t    expected_decodes[$];

	phase_t     model_phase = PH_IDLE;
	logic [3:0] model_nibble = 4'h0;

	int tx_idle_pct = 28;
	int rx_idle_pct = 74;
	int rx_hold_left = 0;
	int chars_queued = 0;
	int chars_accepted = 0;
	int bytes_seen = 0;
	int strings_closed = 0;
	int errors_seen = 0;
	int mismatches = 0;

	quoted_string_unescaper_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic int nibble_of_char(logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
		if (c >= CH_LA && c <= CH_LF_HEX) return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	function automatic bit escape_known(logic [7:0] c);
		return c == CH_T || c == CH_N || c == CH_R || c == CH_QUOTE || c == CH_SQUOTE ||
			c == CH_BSLASH || c == CH_X;
	endfunction

	function automatic logic [7:0] random_hex_digit();
		int v;
		v = $urandom_range(15);
		if (v < 10) return CH_0 + 8'(v);
		return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(v - 10);
	endfunction

	task automatic unescape_char(input logic [7:0] c, input logic at_end);
		decode_t r;
		err_t    err;
		bit      emit;
		int      d;
		err = ERR_NONE;
		emit = 0;
		r.kind = KIND_DATA;
		r.byte_val = 8'h00;
		r.last = 1'b0;
		case (model_phase)
			PH_BODY: begin
				if (at_end) err = ERR_EOF;
				else if (c == CH_LF) err = ERR_NEWLINE;
				else if (c == CH_QUOTE) begin
					model_phase = PH_IDLE;
					emit = 1;
					r.kind = KIND_DONE;
					r.last = 1'b1;
				end else if (c == CH_BSLASH) model_phase = PH_ESC;
				else begin
					emit = 1;
					r.byte_val = c;
				end
			end
			PH_ESC: begin
				if (at_end) err = ERR_ESCAPE;
				else begin
					model_phase = PH_BODY;
					emit = 1;
					case (c)
						CH_T: r.byte_val = CH_TAB;
						CH_N: r.byte_val = CH_LF;
						CH_R: r.byte_val = CH_CR;
						CH_QUOTE, CH_SQUOTE, CH_BSLASH: r.byte_val = c;
						CH_X: begin
							emit = 0;
							model_phase = PH_HEX1;
							model_nibble = 4'h0;
						end
						default: err = ERR_ESCAPE;
					endcase
				end
			end
			PH_HEX1: begin
				d = at_end ? -1 : nibble_of_char(c);
				if (d < 0) err = ERR_HEX;
				else begin
					model_nibble = d[3:0];
					model_phase = PH_HEX2;
				end
			end
			PH_HEX2: begin
				d = at_end ? -1 : nibble_of_char(c);
				if (d < 0) err = ERR_HEX;
				else begin
					model_phase = PH_BODY;
					emit = 1;
					r.byte_val = {model_nibble, d[3:0]};
					model_nibble = 4'h0;
				end
			end
			default: begin
				if (at_end || c != CH_QUOTE) err = ERR_NOQUOTE;
				else begin
					model_phase = PH_BODY;
					model_nibble = 4'h0;
				end
			end
		endcase
		if (err != ERR_NONE) begin
			model_phase = PH_IDLE;
			model_nibble = 4'h0;
			emit = 1;
			r.kind = KIND_ERR;
			r.byte_val = 8'h00;
			r.last = 1'b1;
		end
		r.err = err;
		if (emit) expected_decodes = {expected_decodes, r};
	endtask

	task automatic add(input logic [7:0] c, input logic at_end);
		char_beat_t b;
		b.ch = c;
		b.at_end = at_end;
		pending_chars = {pending_chars, b};
		chars_queued++;
	endtask

	task automatic add_end();
		add(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic add_body_token();
		logic [7:0] c;
		int         sel;
		sel = $urandom_range(9);
		if (sel < 5) begin
			do c = 8'($urandom_range(255));
			while (c == CH_QUOTE || c == CH_BSLASH || c == CH_LF);
			add(c, 1'b0);
		end else if (sel < 8) begin
			add(CH_BSLASH, 1'b0);
			case ($urandom_range(5))
				0: add(CH_T, 1'b0);
				1: add(CH_N, 1'b0);
				2: add(CH_R, 1'b0);
				3: add(CH_QUOTE, 1'b0);
				4: add(CH_SQUOTE, 1'b0);
				default: add(CH_BSLASH, 1'b0);
			endcase
		end else begin
			add(CH_BSLASH, 1'b0);
			add(CH_X, 1'b0);
			add(random_hex_digit(), 1'b0);
			add(random_hex_digit(), 1'b0);
		end
	endtask

	task automatic add_broken_tail();
		logic [7:0] c;
		case ($urandom_range(3))
			0: add_end();
			1: add(CH_LF, 1'b0);
			2: begin
				add(CH_BSLASH, 1'b0);
				if ($urandom_range(3) == 0) add_end();
				else begin
					do c = 8'($urandom_range(255));
					while (escape_known(c));
					add(c, 1'b0);
				end
			end
			default: begin
				add(CH_BSLASH, 1'b0);
				add(CH_X, 1'b0);
				if ($urandom_range(1)) add(random_hex_digit(), 1'b0);
				if ($urandom_range(3) == 0) add_end();
				else begin
					do c = 8'($urandom_range(255));
					while (nibble_of_char(c) >= 0);
					add(c, 1'b0);
				end
			end
		endcase
	endtask

	task automatic queue_strings(input int count);
		int target;
		int pick;
		int len;
		target = chars_queued + count;
		while (chars_queued < target) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				if ($urandom_range(1)) add_end();
				else add(8'($urandom_range(255)), 1'b0);
			end else begin
				len = $urandom_range(8);
				add(CH_QUOTE, 1'b0);
				for (int i = 0; i < len; i++) add_body_token();
				if (pick < 75) add(CH_QUOTE, 1'b0);
				else add_broken_tail();
			end
		end
	endtask

	task automatic settle();
		while (pending_chars.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (expected_decodes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	always @(posedge clk) begin
		char_beat_t beat;
		if (s_axis_tvalid && s_axis_tready) begin
			unescape_char(s_axis_tdata, s_axis_tuser[0]);
			chars_accepted++;
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (arst_n && pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				beat = pending_chars.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= beat.ch;
				s_axis_tuser <= beat.at_end;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		decode_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_decodes.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result beat: kind %0d byte %02h err %0d last %0b",
						m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8], m_axis_tlast);
				mismatches++;
			end else begin
				want = expected_decodes.pop_front();
				case (want.kind)
					KIND_DATA: bytes_seen++;
					KIND_DONE: strings_closed++;
					default: errors_seen++;
				endcase
				if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.byte_val ||
						m_axis_tdata[10:8] !== want.err || m_axis_tlast !== want.last ||
						m_axis_tdata[ODATA_W-1:11] !== '0) begin
					if (mismatches < 10)
						$display("mismatch: expected kind %0d byte %02h err %0d last %0b, %s",
							want.kind, want.byte_val, want.err, want.last,
							$sformatf("got kind %0d byte %02h err %0d last %0b pad %0h",
								m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8],
								m_axis_tlast, m_axis_tdata[ODATA_W-1:11]));
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stray input while idle, then a string of plain bytes, escapes and \x
		add_end();
		add(8'h61, 1'b0);
		add(CH_QUOTE, 1'b0);
		add(8'h00, 1'b0);
		add(8'hFF, 1'b0);
		add(CH_TAB, 1'b0);
		add(CH_CR, 1'b0);
		add(CH_BSLASH, 1'b0);
		add(CH_T, 1'b0);
		add(CH_BSLASH, 1'b0);
		add(CH_X, 1'b0);
		add(CH_9, 1'b0);
		add(CH_LA, 1'b0);
		add(CH_QUOTE, 1'b0);
		// raw newline, end inside body, after backslash, unknown escape, truncated and bad hex
		add(CH_QUOTE, 1'b0);
		add(CH_LF, 1'b0);
		add(CH_QUOTE, 1'b0);
		add_end();
		add(CH_QUOTE, 1'b0);
		add(CH_BSLASH, 1'b0);
		add_end();
		add(CH_QUOTE, 1'b0);
		add(CH_BSLASH, 1'b0);
		add(8'h71, 1'b0);
		add(CH_QUOTE, 1'b0);
		add(CH_BSLASH, 1'b0);
		add(CH_X, 1'b0);
		add(CH_UF, 1'b0);
		add_end();
		add(CH_QUOTE, 1'b0);
		add(CH_BSLASH, 1'b0);
		add(CH_X, 1'b0);
		add(8'h67, 1'b0);

		queue_strings(140);
		settle();

		@(negedge clk);
		tx_idle_pct = 74;
		rx_idle_pct = 28;
		queue_strings(140);
		settle();

		// hold the result side off while characters keep arriving
		@(negedge clk);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_left = 80;
		queue_strings(140);
		settle();

		if (expected_decodes.size() != 0) begin
			$display("%0d expected results never arrived", expected_decodes.size());
			mismatches += expected_decodes.size();
		end
		$display("%0d characters accepted under three flow-control mixes and a long output stall",
			chars_accepted);
		$display("results: %0d bytes, %0d strings closed, %0d errors, %0d mismatches",
			bytes_seen, strings_closed, errors_seen, mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
